// ----- design/vdts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the voxel density sampler.
// Used by every module of the design; depends on nothing.
package vdts_pkg;

	localparam int CHUNK_EDGE       = 16;
	localparam int CHUNKS_PER_SIDE  = 8;
	localparam int MAX_BRUSH_RADIUS = 8;

	localparam int SPAN_XZ     = CHUNKS_PER_SIDE * CHUNK_EDGE;
	localparam int SPAN_Y      = CHUNK_EDGE + 1;
	localparam int STORE_DEPTH = SPAN_XZ * SPAN_Y * SPAN_XZ;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int XZ_W        = $clog2(SPAN_XZ);
	localparam int Y_W         = $clog2(SPAN_Y);

	localparam int DENS_W  = 16;
	localparam int POS_W   = 17;
	localparam int RAD_W   = 12;
	localparam int FRAC_W  = 8;
	localparam int W1_W    = FRAC_W + 1;
	localparam int COORD_W = 12;
	localparam int SAT_W   = 24;
	localparam int ACC_W   = 42;

	localparam int RMAX  = MAX_BRUSH_RADIUS * 256;
	localparam int RC_W  = $clog2(RMAX + 1);
	localparam int R2_W  = 2 * RC_W;
	localparam int IR_W  = $clog2(MAX_BRUSH_RADIUS + 1);
	localparam int D_W   = IR_W + 1;
	localparam int SQ_W  = 2 * D_W + 2;
	localparam int CMP_W = SQ_W + 16;

	localparam int QDEPTH = 2;
	localparam int QP_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_BRUSH  = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic REG_SOLID = 1'b0;
	localparam logic REG_AIR   = 1'b1;

	localparam logic signed [DENS_W-1:0] SOLID_RESET = 16'sd2560;
	localparam logic signed [DENS_W-1:0] AIR_RESET   = -16'sd2560;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DENS_W-1:0] dens_t;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_SAMPLE,
		OP_BRUSH,
		OP_SOLID,
		OP_AIR,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t               op;
		coord_t            ix;
		coord_t            iy;
		coord_t            iz;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [FRAC_W-1:0] fz;
		dens_t             value;
		logic [IR_W-1:0]   ir;
		logic [R2_W-1:0]   r2;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_SAMPLE,
		ST_BRUSH_RD,
		ST_BRUSH_WR,
		ST_FINISH
	} st_t;

	function automatic logic in_grid(coord_t x, coord_t y, coord_t z);
		return (x >= 0) && (x < coord_t'(SPAN_XZ)) && (y >= 0) &&
			(y <= coord_t'(CHUNK_EDGE)) && (z >= 0) && (z < coord_t'(SPAN_XZ));
	endfunction

	function automatic logic [ADDR_W-1:0] voxel_addr(coord_t x, coord_t y, coord_t z);
		return ADDR_W'(x[XZ_W-1:0]) * ADDR_W'(SPAN_Y * SPAN_XZ) +
			ADDR_W'(y[Y_W-1:0]) * ADDR_W'(SPAN_XZ) + ADDR_W'(z[XZ_W-1:0]);
	endfunction

	function automatic dens_t sat16(logic signed [SAT_W-1:0] v);
		if (v > SAT_W'(32767)) begin
			return 16'sh7FFF;
		end else if (v < -SAT_W'(32768)) begin
			return -16'sh8000;
		end
		return v[DENS_W-1:0];
	endfunction

endpackage

// ----- design/vdts_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts items, splits positions into integer and fraction parts,
// rounds brush centres and prepares the brush radius. Depends on vdts_pkg.
module vdts_front (
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        func,
	input  logic signed [vdts_pkg::POS_W-1:0] pos_x,
	input  logic signed [vdts_pkg::POS_W-1:0] pos_y,
	input  logic signed [vdts_pkg::POS_W-1:0] pos_z,
	input  logic signed [vdts_pkg::DENS_W-1:0] value,
	input  logic [vdts_pkg::RAD_W-1:0]        radius,
	input  vdts_pkg::q_stat_t                 q_stat,
	input  vdts_pkg::back_stat_t              back_stat,
	output logic                              push,
	output vdts_pkg::entry_t                  entry
);
	import vdts_pkg::*;

	logic [RC_W-1:0] rc;
	logic            is_brush;

	function automatic coord_t round_q8(logic signed [POS_W-1:0] p);
		logic signed [POS_W:0] pe;
		logic signed [POS_W:0] m;
		logic [POS_W:0]        t;
		pe = {p[POS_W-1], p};
		m  = p[POS_W-1] ? -pe : pe;
		t  = $unsigned(m + (POS_W + 1)'(128)) >> FRAC_W;
		return p[POS_W-1] ? -coord_t'(t) : coord_t'(t);
	endfunction

	function automatic coord_t floor_q8(logic signed [POS_W-1:0] p);
		return coord_t'(p >>> FRAC_W);
	endfunction

	assign req_stall = q_stat.full | back_stat.clearing;
	assign push      = req_valid & ~req_stall;
	assign is_brush  = (func == FUNC_BRUSH);

	always_comb begin
		rc = (int'(radius) > RMAX) ? RC_W'(RMAX) : RC_W'(radius);
		unique case (func)
			FUNC_WRITE: entry.op = OP_WRITE;
			FUNC_SAMPLE: begin
				if (pos_y < 0) begin
					entry.op = OP_SOLID;
				end else if (pos_y > POS_W'(CHUNK_EDGE * 256)) begin
					entry.op = OP_AIR;
				end else begin
					entry.op = OP_SAMPLE;
				end
			end
			FUNC_BRUSH: entry.op = OP_BRUSH;
			FUNC_NONE:  entry.op = OP_NONE;
		endcase
		entry.ix    = is_brush ? round_q8(pos_x) : floor_q8(pos_x);
		entry.iy    = is_brush ? round_q8(pos_y) : floor_q8(pos_y);
		entry.iz    = is_brush ? round_q8(pos_z) : floor_q8(pos_z);
		entry.fx    = pos_x[FRAC_W-1:0];
		entry.fy    = pos_y[FRAC_W-1:0];
		entry.fz    = pos_z[FRAC_W-1:0];
		entry.value = value;
		entry.ir    = IR_W'((int'(rc) + 255) >> FRAC_W);
		entry.r2    = R2_W'(rc) * R2_W'(rc);
	end

endmodule

// ----- design/vdts_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of classified items between the front end
// and the back end. Depends on vdts_pkg.
module vdts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vdts_pkg::entry_t  push_entry,
	input  logic              pop,
	output vdts_pkg::entry_t  head,
	output vdts_pkg::q_stat_t q_stat
);
	import vdts_pkg::*;

	entry_t          ent_q [QDEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == QC_W'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(pop);
		end
	end

endmodule

// ----- design/vdts_back.sv -----
`timescale 1ns / 1ps
// Back end: density memory with its clearing pass, write, pipelined eight-corner
// trilinear sample, brush cube walk and the result register. Depends on vdts_pkg.
module vdts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vdts_pkg::entry_t     head,
	input  vdts_pkg::q_stat_t    q_stat,
	output logic                 pop,
	input  vdts_pkg::dens_t      solid,
	input  vdts_pkg::dens_t      air,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output vdts_pkg::dens_t      density,
	output vdts_pkg::back_stat_t back_stat
);
	import vdts_pkg::*;

	st_t                     state_q, state_d;
	entry_t                  cur_q;
	logic [ADDR_W-1:0]       clr_q;
	dens_t                   mem [STORE_DEPTH];
	dens_t                   rd_q;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_addr;
	dens_t                   mem_wdata;

	logic [3:0]              iss_q;
	logic                    v_s1, v_s2, v_s3;
	logic                    oob_s1;
	logic [2*W1_W-1:0]       wxy_s1;
	logic [W1_W-1:0]         wz_s1;
	dens_t                   vox_s2;
	logic [3*W1_W-1:0]       w_s2;
	logic signed [ACC_W-1:0] prod_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_rnd;
	dens_t                   res_q;
	dens_t                   density_q;
	logic                    rsp_valid_q;

	logic signed [D_W-1:0]   dx_q, dy_q, dz_q;
	logic signed [D_W-1:0]   ir_s;
	logic signed [D_W-1:0]   head_ir_s;
	logic [SQ_W-1:0]         sq;
	logic                    in_sphere, touch, last;
	coord_t                  bx, by, bz;
	coord_t                  sx, sy, sz;
	logic [W1_W-1:0]         wx, wy, wz;

	logic issue, samp_done, adv, load_out, clr_last;

	assign rsp_valid          = rsp_valid_q;
	assign density            = density_q;
	assign back_stat.clearing = (state_q == ST_CLEAR);

	always_comb begin
		sx = cur_q.ix + coord_t'(iss_q[0]);
		sy = cur_q.iy + coord_t'(iss_q[1]);
		sz = cur_q.iz + coord_t'(iss_q[2]);
		wx = iss_q[0] ? W1_W'(cur_q.fx) : W1_W'(256) - W1_W'(cur_q.fx);
		wy = iss_q[1] ? W1_W'(cur_q.fy) : W1_W'(256) - W1_W'(cur_q.fy);
		wz = iss_q[2] ? W1_W'(cur_q.fz) : W1_W'(256) - W1_W'(cur_q.fz);
		bx = cur_q.ix + coord_t'(dx_q);
		by = cur_q.iy + coord_t'(dy_q);
		bz = cur_q.iz + coord_t'(dz_q);
		sq = $unsigned(SQ_W'(dx_q) * SQ_W'(dx_q) + SQ_W'(dy_q) * SQ_W'(dy_q) +
			SQ_W'(dz_q) * SQ_W'(dz_q));
		in_sphere = {sq, 16'b0} <= CMP_W'(cur_q.r2);
		touch     = in_sphere & in_grid(bx, by, bz);
		ir_s      = $signed({1'b0, cur_q.ir});
		head_ir_s = $signed({1'b0, head.ir});
		last      = (dx_q == ir_s) && (dy_q == ir_s) && (dz_q == ir_s);
		clr_last  = (clr_q == ADDR_W'(STORE_DEPTH - 1));
		acc_rnd   = (acc_q + ACC_W'(1 << 23)) >>> 24;
		samp_done = iss_q[3] & ~v_s1 & ~v_s2 & ~v_s3;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					unique case (head.op)
						OP_WRITE:  state_d = ST_WRITE;
						OP_SAMPLE: state_d = ST_SAMPLE;
						OP_BRUSH:  state_d = ST_BRUSH_RD;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_WRITE: state_d = ST_FINISH;
			ST_SAMPLE: begin
				if (samp_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_BRUSH_RD: begin
				if (touch) begin
					state_d = ST_BRUSH_WR;
				end else if (last) begin
					state_d = ST_FINISH;
				end
			end
			ST_BRUSH_WR: state_d = last ? ST_FINISH : ST_BRUSH_RD;
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = voxel_addr(bx, by, bz);
		mem_wdata = sat16(SAT_W'(rd_q) + SAT_W'(cur_q.value));
		issue     = 1'b0;
		adv       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: pop = ~q_stat.empty;
			ST_WRITE: begin
				mem_we    = in_grid(cur_q.ix, cur_q.iy, cur_q.iz);
				mem_addr  = voxel_addr(cur_q.ix, cur_q.iy, cur_q.iz);
				mem_wdata = cur_q.value;
			end
			ST_SAMPLE: begin
				mem_addr = voxel_addr(sx, sy, sz);
				issue    = ~iss_q[3];
			end
			ST_BRUSH_RD: adv = ~touch;
			ST_BRUSH_WR: begin
				mem_we = 1'b1;
				adv    = 1'b1;
			end
			ST_FINISH: load_out = ~rsp_valid_q | ~rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			iss_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			acc_q <= '0;
			dx_q  <= -head_ir_s;
			dy_q  <= -head_ir_s;
			dz_q  <= -head_ir_s;
			unique case (head.op)
				OP_SOLID: res_q <= solid;
				OP_AIR:   res_q <= air;
				default:  res_q <= '0;
			endcase
		end else begin
			if (v_s3) begin
				acc_q <= acc_q + prod_s3;
			end
			if (state_q == ST_SAMPLE && samp_done) begin
				res_q <= sat16(SAT_W'(acc_rnd));
			end
			if (adv) begin
				if (dz_q != ir_s) begin
					dz_q <= dz_q + 1'b1;
				end else begin
					dz_q <= -ir_s;
					if (dy_q != ir_s) begin
						dy_q <= dy_q + 1'b1;
					end else begin
						dy_q <= -ir_s;
						dx_q <= dx_q + 1'b1;
					end
				end
			end
		end
		oob_s1  <= ~in_grid(sx, sy, sz);
		wxy_s1  <= (2 * W1_W)'(wx) * (2 * W1_W)'(wy);
		wz_s1   <= wz;
		vox_s2  <= oob_s1 ? air : rd_q;
		w_s2    <= (3 * W1_W)'(wxy_s1) * (3 * W1_W)'(wz_s1);
		prod_s3 <= ACC_W'(vox_s2) * ACC_W'($signed({1'b0, w_s2}));
		if (load_out) begin
			density_q <= res_q;
		end
	end

endmodule

// ----- design/voxel_density_trilinear_sampler.sv -----
`timescale 1ns / 1ps
// Voxel density sampler top level. After reset the memory is cleared one voxel
// a cycle, all 278528 voxels; no item is accepted meanwhile, configuration is.
// A sample makes eight corner reads through one memory port, then runs a
// three-stage multiply pipeline and the accumulate; a brush reads every voxel
// of its cube and writes each voxel it touches. Items run one at a time behind
// a two-entry queue.
module voxel_density_trilinear_sampler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         func,
	input  logic signed [vdts_pkg::POS_W-1:0]  pos_x,
	input  logic signed [vdts_pkg::POS_W-1:0]  pos_y,
	input  logic signed [vdts_pkg::POS_W-1:0]  pos_z,
	input  logic signed [vdts_pkg::DENS_W-1:0] value,
	input  logic [vdts_pkg::RAD_W-1:0]         radius,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic signed [vdts_pkg::DENS_W-1:0] density,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic signed [vdts_pkg::DENS_W-1:0] cfg_data
);
	import vdts_pkg::*;

	dens_t      solid_q;
	dens_t      air_q;
	q_stat_t    q_stat;
	back_stat_t back_stat;
	entry_t     push_entry;
	entry_t     head;
	logic       push;
	logic       pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= SOLID_RESET;
			air_q   <= AIR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOLID: solid_q <= cfg_data;
				REG_AIR:   air_q   <= cfg_data;
			endcase
		end
	end

	vdts_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.value     (value),
		.radius    (radius),
		.q_stat    (q_stat),
		.back_stat (back_stat),
		.push      (push),
		.entry     (push_entry)
	);

	vdts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	vdts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.solid     (solid_q),
		.air       (air_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.density   (density),
		.back_stat (back_stat)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> req_stall)
		else $error("item accepted during memory clear");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_empty_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(back_stat.clearing) |-> q_stat.empty)
		else $error("queue holds an item at the end of the clear");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of voxel_density_trilinear_sampler: directed table then random items,
// each result checked against the table's expected value or a behavioral model of the density grid held here.
// Depends on vdts_pkg and the voxel_density_trilinear_sampler RTL only.
module testbench;
	import vdts_pkg::*;

	localparam int WATCHDOG_LIMIT = 1200000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [1:0] fn;
		int         px;
		int         py;
		int         pz;
		int         val;
		int         rad;
		bit         known;
		int         want;
	} vec_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] func;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [DENS_W-1:0] value;
	logic [RAD_W-1:0] radius;
	logic rsp_valid;
	logic rsp_stall;
	logic signed [DENS_W-1:0] density;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic signed [DENS_W-1:0] cfg_data;

	logic signed [DENS_W-1:0] voxel_grid [STORE_DEPTH];
	int solid_level;
	int air_level;
	int expected_density [$];
	int errors;
	bit quiet;
	int starved;

	voxel_density_trilinear_sampler dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.func(func), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .value(value),
		.radius(radius), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .density(density),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int clip16(longint v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return int'(v);
	endfunction

	function automatic bit on_grid(int x, int y, int z);
		return x >= 0 && x < SPAN_XZ && z >= 0 && z < SPAN_XZ && y >= 0 && y <= CHUNK_EDGE;
	endfunction

	function automatic int grid_index(int x, int y, int z);
		return (x * SPAN_Y + y) * SPAN_XZ + z;
	endfunction

	function automatic int voxel_at(int x, int y, int z);
		if (y < 0) begin
			return solid_level;
		end
		if (!on_grid(x, y, z)) begin
			return air_level;
		end
		return voxel_grid[grid_index(x, y, z)];
	endfunction

	function automatic void set_voxel(int x, int y, int z, int v);
		if (on_grid(x, y, z)) begin
			voxel_grid[grid_index(x, y, z)] = DENS_W'(clip16(v));
		end
	endfunction

	function automatic int nearest_voxel(int p);
		if (p >= 0) begin
			return (p + 128) / 256;
		end
		return -((-p + 128) / 256);
	endfunction

	function automatic int blend_density(int px, int py, int pz);
		int ix, iy, iz, fx, fy, fz;
		longint acc, w;
		acc = 0;
		if (py < 0) begin
			return solid_level;
		end
		if (py > CHUNK_EDGE * 256) begin
			return air_level;
		end
		ix = px >>> 8;
		iy = py >>> 8;
		iz = pz >>> 8;
		fx = px & 255;
		fy = py & 255;
		fz = pz & 255;
		for (int c = 0; c < 8; c++) begin
			w = longint'(c[0] ? fx : 256 - fx) * (c[1] ? fy : 256 - fy) * (c[2] ? fz : 256 - fz);
			acc += longint'(voxel_at(ix + c[0], iy + c[1], iz + c[2])) * w;
		end
		return clip16((acc + (longint'(1) << 23)) >>> 24);
	endfunction

	function automatic void apply_brush(int px, int py, int pz, int delta, int r);
		int cx, cy, cz, ir;
		longint r2;
		cx = nearest_voxel(px);
		cy = nearest_voxel(py);
		cz = nearest_voxel(pz);
		if (r > MAX_BRUSH_RADIUS * 256) begin
			r = MAX_BRUSH_RADIUS * 256;
		end
		ir = (r + 255) / 256;
		r2 = longint'(r) * r;
		for (int dx = -ir; dx <= ir; dx++) begin
			for (int dy = -ir; dy <= ir; dy++) begin
				for (int dz = -ir; dz <= ir; dz++) begin
					if (longint'(dx * dx + dy * dy + dz * dz) * 65536 <= r2) begin
						set_voxel(cx + dx, cy + dy, cz + dz,
							voxel_at(cx + dx, cy + dy, cz + dz) + delta);
					end
				end
			end
		end
	endfunction

	function automatic int predict_density(vec_t v);
		case (v.fn)
			FUNC_WRITE: begin
				set_voxel(v.px >>> 8, v.py >>> 8, v.pz >>> 8, v.val);
			end
			FUNC_SAMPLE: begin
				return blend_density(v.px, v.py, v.pz);
			end
			FUNC_BRUSH: begin
				apply_brush(v.px, v.py, v.pz, v.val, v.rad);
			end
			default: begin
			end
		endcase
		return 0;
	endfunction

	task automatic send_item(vec_t v);
		int want;
		if (!quiet && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		func <= v.fn;
		pos_x <= POS_W'(v.px);
		pos_y <= POS_W'(v.py);
		pos_z <= POS_W'(v.pz);
		value <= DENS_W'(v.val);
		radius <= RAD_W'(v.rad);
		req_valid <= 1'b1;
		forever begin
			@(negedge clk);
			if (!req_stall) begin
				break;
			end
			@(posedge clk);
		end
		@(posedge clk);
		want = predict_density(v);
		expected_density = {expected_density, v.known ? v.want : want};
	endtask

	task automatic write_register(logic idx, int data);
		cfg_index <= idx;
		cfg_data <= DENS_W'(data);
		cfg_valid <= 1'b1;
		forever begin
			@(negedge clk);
			if (cfg_ready) begin
				break;
			end
			@(posedge clk);
		end
		@(posedge clk);
		if (idx == REG_SOLID) begin
			solid_level = data;
		end else begin
			air_level = data;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_density.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int random_coord(int sel, int top);
		if (sel < 55) begin
			return $urandom_range(0, 10 * 256) - 256;
		end else if (sel < 85) begin
			return $urandom_range(0, (top + 4) * 256) - 512;
		end
		return int'($urandom_range(0, 131071)) - 65536;
	endfunction

	function automatic vec_t random_item();
		vec_t v;
		int sel, pick;
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		v.fn = pick < 30 ? FUNC_WRITE : pick < 75 ? FUNC_SAMPLE : pick < 94 ? FUNC_BRUSH :
			pick < 97 ? FUNC_NONE : 2'($urandom);
		v.px = random_coord(sel, SPAN_XZ);
		v.py = random_coord($urandom_range(99), CHUNK_EDGE);
		v.pz = random_coord(sel, SPAN_XZ);
		v.val = int'($urandom_range(0, 65535)) - 32768;
		if ($urandom_range(9) == 0) begin
			v.val = $urandom_range(1) ? 32767 : -32768;
		end
		v.rad = $urandom_range(99) < 4 ? $urandom_range(0, 4095) : $urandom_range(0, 700);
		v.known = 1'b0;
		v.want = 0;
		return v;
	endfunction

	vec_t directed [] = '{
		'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 1, 0},
		'{FUNC_SAMPLE, 100, -1, 100, 0, 0, 1, 2560},
		'{FUNC_SAMPLE, 0, 4097, 0, 0, 0, 1, -2560},
		'{FUNC_SAMPLE, -512, 0, 0, 0, 0, 1, -2560},
		'{FUNC_WRITE, 0, 0, 0, 32767, 0, 1, 0},
		'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 1, 32767},
		'{FUNC_WRITE, 127 * 256, 16 * 256, 127 * 256, -32768, 0, 1, 0},
		'{FUNC_SAMPLE, 127 * 256, 16 * 256, 127 * 256, 0, 0, 1, -32768},
		'{FUNC_WRITE, -1, 0, 0, 500, 0, 1, 0},
		'{FUNC_WRITE, 65535, 65535, 65535, 1, 4095, 1, 0},
		'{FUNC_WRITE, -65536, -65536, -65536, -1, 0, 1, 0},
		'{FUNC_NONE, 256, 256, 256, 999, 100, 1, 0},
		'{FUNC_BRUSH, 512, 512, 512, 32767, 0, 1, 0},
		'{FUNC_BRUSH, 384, 384, 384, -32768, 4095, 1, 0},
		'{FUNC_BRUSH, -128, -128, -128, 1000, 512, 1, 0},
		'{FUNC_SAMPLE, 128, 128, 128, 0, 0, 0, 0},
		'{FUNC_SAMPLE, 640, 300, 700, 0, 0, 0, 0},
		'{FUNC_SAMPLE, 65535, 65535, 65535, 0, 0, 1, -2560},
		'{FUNC_SAMPLE, -65536, 0, -65536, 0, 0, 0, 0},
		'{FUNC_BRUSH, 127 * 256 + 128, 16 * 256, 0, 123, 300, 1, 0},
		'{FUNC_SAMPLE, 127 * 256 + 200, 16 * 256, 10, 0, 0, 0, 0},
		'{FUNC_SAMPLE, 100, 4096, 100, 0, 0, 0, 0}
	};

	initial begin
		int solid_set [4];
		int air_set [4];
		for (int i = 0; i < STORE_DEPTH; i++) begin
			voxel_grid[i] = '0;
		end
		solid_level = 2560;
		air_level = -2560;
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		func = FUNC_NONE;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		value = '0;
		radius = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SOLID;
		cfg_data = '0;
		solid_set = '{2560, 32767, -32768, int'($urandom_range(0, 65535)) - 32768};
		air_set = '{-2560, -32768, 32767, int'($urandom_range(0, 65535)) - 32768};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			write_register(REG_SOLID, solid_set[ph]);
			write_register(REG_AIR, air_set[ph]);
			if (ph == 0) begin
				foreach (directed[i]) begin
					send_item(directed[i]);
				end
			end
			for (int n = 0; n < 250; n++) begin
				quiet = ph == 1 && n >= 50 && n < 200;
				if (ph == 2 && n == 120) begin
					drain();
				end
				send_item(random_item());
			end
			quiet = 1'b0;
			drain();
		end
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		bit req_take, rsp_take;
		logic signed [DENS_W-1:0] got;
		int want;
		rsp_stall = 1'b0;
		starved = 0;
		forever begin
			@(negedge clk);
			req_take = req_valid && !req_stall;
			rsp_take = rsp_valid && !rsp_stall;
			got = density;
			@(posedge clk);
			if (rsp_take) begin
				if (expected_density.size() == 0) begin
					$display("%t: unexpected item, density actual %0d", $time, got);
					errors++;
				end else begin
					want = expected_density.pop_front();
					if (int'(got) != want) begin
						$display("%t: density expected %0d actual %0d", $time, want, got);
						errors++;
					end
				end
			end
			starved = (req_take || rsp_take) ? 0 : starved + 1;
			if (starved >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
			rsp_stall <= !quiet && $urandom_range(99) < 19;
		end
	end

endmodule

// ----- filelist.f -----
design/vdts_pkg.sv
design/vdts_front.sv
design/vdts_queue.sv
design/vdts_back.sv
design/voxel_density_trilinear_sampler.sv
bench/testbench.sv
